// ===== rtl/hptt_pkg.sv =====
// ----------------------------------------------------------------------------
// hptt_pkg
// Shared constants, codes, control structs and hash for the hashed page
// translation table.
// ----------------------------------------------------------------------------
package hptt_pkg;

	localparam int ADDR_W           = 32;
	localparam int PAGE_OFFSET_BITS = 12;
	localparam int TAG_W            = ADDR_W - PAGE_OFFSET_BITS;
	// slot count, must be a power of two
	localparam int TABLE_ENTRIES    = 256;
	localparam int IDX_W            = $clog2(TABLE_ENTRIES);
	localparam int ENTRY_W          = TAG_W + ADDR_W;

	localparam logic       FUNC_LOOKUP = 1'b0;
	localparam logic       FUNC_INSERT = 1'b1;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_MISS = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture the request
		logic hash;     // compute home slot, clear probe count
		logic read;     // registered read of the current slot
		logic advance;  // move to next slot
		logic finish;   // produce result, write on insert
	} hptt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic slot_free;
		logic slot_match;
		logic last_probe;
	} hptt_sts_t;

	function automatic logic [63:0] mix64(input logic [63:0] x_in);
		logic [63:0] x;
		x = x_in;
		x = x ^ (x << 3);
		x = x ^ (x >> 10);
		x = x ^ (x << 6);
		x = x ^ (x << 20);
		x = x ^ (x >> 14);
		x = x ^ (x << 17);
		return x;
	endfunction

endpackage

// ===== rtl/hptt_ctrl.sv =====
// ----------------------------------------------------------------------------
// hptt_ctrl
// Sequencer: hash, then read/check per probe until a free slot, a tag match
// or a full pass ends the search.
// ----------------------------------------------------------------------------
module hptt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  hptt_pkg::hptt_sts_t sts,
	output hptt_pkg::hptt_cmd_t cmd
);
	import hptt_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_HASH  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_CHECK = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       stop;
	logic       done_q;

	assign stop = sts.slot_free | sts.slot_match | sts.last_probe;

	always_comb begin
		state_nxt   = state_q;
		cmd         = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = ST_HASH;
				end
			end
			ST_HASH: begin
				cmd.hash  = 1'b1;
				state_nxt = ST_READ;
			end
			ST_READ: begin
				cmd.read  = 1'b1;
				state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				if (stop) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end else begin
					cmd.advance = 1'b1;
					state_nxt   = ST_READ;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= cmd.finish;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

// ===== rtl/hptt_dp.sv =====
// ----------------------------------------------------------------------------
// hptt_dp
// Request registers, hash, probe index/count, slot memory with valid bits,
// and result registers.
// ----------------------------------------------------------------------------
module hptt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          func,
	input  logic [hptt_pkg::ADDR_W-1:0]   virt_addr,
	input  logic [hptt_pkg::ADDR_W-1:0]   phys_base,
	input  hptt_pkg::hptt_cmd_t           cmd,
	output hptt_pkg::hptt_sts_t           sts,
	output logic [1:0]                    status,
	output logic [hptt_pkg::ADDR_W-1:0]   phys_addr
);
	import hptt_pkg::*;

	logic                func_q;
	logic [ADDR_W-1:0]   va_q;
	logic [ADDR_W-1:0]   base_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    cnt_q;
	logic [ENTRY_W-1:0]  mem_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [ENTRY_W-1:0]  rd_q;
	logic                rd_valid_q;
	logic [1:0]          status_q;
	logic [ADDR_W-1:0]   phys_q;

	logic [TAG_W-1:0]    tag;
	logic [ADDR_W-1:0]   aligned;
	logic [63:0]         hash;
	logic [TAG_W-1:0]    rd_tag;
	logic [ADDR_W-1:0]   rd_base;
	logic [ADDR_W-1:0]   sum;
	logic                found;
	logic                do_write;

	assign tag     = va_q[ADDR_W-1:PAGE_OFFSET_BITS];
	assign aligned = {tag, {PAGE_OFFSET_BITS{1'b0}}};
	assign hash    = mix64({32'b0, aligned});
	assign rd_tag  = rd_q[ENTRY_W-1:ADDR_W];
	assign rd_base = rd_q[ADDR_W-1:0];
	assign sum     = rd_base + {{TAG_W{1'b0}}, va_q[PAGE_OFFSET_BITS-1:0]};

	assign sts.slot_free  = !rd_valid_q;
	assign sts.slot_match = rd_valid_q && (rd_tag == tag);
	assign sts.last_probe = (cnt_q == IDX_W'(TABLE_ENTRIES - 1));

	assign found    = sts.slot_free | sts.slot_match;
	assign do_write = cmd.finish && (func_q == FUNC_INSERT) && found;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			va_q   <= virt_addr;
			base_q <= phys_base;
		end
		if (cmd.hash) begin
			idx_q <= IDX_W'(hash % 64'(TABLE_ENTRIES));
			cnt_q <= '0;
		end else if (cmd.advance) begin
			idx_q <= (idx_q == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : idx_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (do_write)
			mem_q[idx_q] <= {tag, base_q};
		if (cmd.read)
			rd_q <= mem_q[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (do_write)
				valid_q[idx_q] <= 1'b1;
			if (cmd.read)
				rd_valid_q <= valid_q[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (func_q == FUNC_INSERT) begin
				status_q <= found ? STATUS_OK : STATUS_FULL;
				phys_q   <= '0;
			end else if (sts.slot_match) begin
				status_q <= STATUS_OK;
				phys_q   <= sum;
			end else begin
				status_q <= STATUS_MISS;
				phys_q   <= '0;
			end
		end
	end

	assign status    = status_q;
	assign phys_addr = phys_q;

endmodule

// ===== rtl/hashed_page_translation_table_unit.sv =====
// ----------------------------------------------------------------------------
// hashed_page_translation_table_unit
// Hashed page table with linear probing: insert a page mapping or look up
// a virtual address.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat (func, virt_addr, phys_base) is taken on a clock edge with
//   start high and busy low. func selects lookup or insert. Exactly one
//   result beat follows: done is high for one cycle with status and
//   phys_addr valid; the receiver must take it then.
//   Sequence: the HASH state hashes the page address to its home slot, then
//   each probe passes through READ (registered slot memory read) and then
//   CHECK (tag check). done rises on the same edge that drops busy, and no
//   new request is taken while busy. The probe loop over the slot memory
//   sets the rate; a search stops at a free slot, a tag match, or after a
//   full pass of all slots (table full / miss).
//   A new request may be started in the same cycle that done is shown.
//   Reset clears all valid bits at once; the table is empty and usable in
//   the first cycle after reset.
// ----------------------------------------------------------------------------
module hashed_page_translation_table_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        func,
	input  logic [hptt_pkg::ADDR_W-1:0] virt_addr,
	input  logic [hptt_pkg::ADDR_W-1:0] phys_base,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [hptt_pkg::ADDR_W-1:0] phys_addr
);
	import hptt_pkg::*;

	hptt_cmd_t cmd;
	hptt_sts_t sts;

	hptt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	hptt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.func      (func),
		.virt_addr (virt_addr),
		.phys_base (phys_base),
		.cmd       (cmd),
		.sts       (sts),
		.status    (status),
		.phys_addr (phys_addr)
	);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("search ended without a result beat");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == STATUS_OK || status == STATUS_MISS || status == STATUS_FULL))
		else $error("result status code out of range");

endmodule
